// File: src/rlcs_pkg.sv
// Package for the RGB LED chain serializer: sizes, request kinds, status codes
// and the small helpers for bit selection and phase length.
// No dependencies.
`default_nettype none
package rlcs_pkg;

    // Color store size and address width
    localparam int LED_SLOTS = 64;
    localparam int LED_AW    = $clog2(LED_SLOTS);

    // Request kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [2:0] CFG_ONE_LOW   = 3'd1;
    localparam logic [2:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [2:0] CFG_ZERO_LOW  = 3'd3;
    localparam logic [2:0] CFG_RESET_LOW = 3'd4;

    // Line phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_RESET = 2'd3;

    // Bit sent at position pos of a color: green, red, blue, MSB first
    function automatic logic grb_bit(input logic [23:0] color, input logic [4:0] pos);
        logic [23:0] grb;
        grb = {color[15:8], color[23:16], color[7:0]};
        return grb[5'd23 - pos];
    endfunction

    // A phase loaded with zero lasts one tick
    function automatic logic [9:0] at_least_one(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

endpackage
`default_nettype wire

// File: src/rlcs_req_if.sv
// Request channel of the LED chain serializer: valid/ready plus request fields.
// Depends on nothing but the standard types.
`default_nettype none
interface rlcs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  led_index;
    logic [23:0] color_value;

    modport source (output valid, kind, led_index, color_value, input ready);
    modport sink   (input valid, kind, led_index, color_value, output ready);
endinterface
`default_nettype wire

// File: src/rlcs_rsp_if.sv
// Response channel of the LED chain serializer: valid/ready plus response fields.
// Depends on nothing but the standard types.
`default_nettype none
interface rlcs_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [23:0] color_out;
    logic        line_level;
    logic        busy_res;
    logic [6:0]  led_count;
    logic        frame_done;

    modport source (output valid, status, color_out, line_level, busy_res, led_count,
                    frame_done, input ready);
    modport sink   (input valid, status, color_out, line_level, busy_res, led_count,
                    frame_done, output ready);
endinterface
`default_nettype wire

// File: src/rgb_led_chain_serializer.sv
// Top level of the RGB LED chain serializer: color store, serial line sequencer.
// Depends on rlcs_pkg, rlcs_req_if and rlcs_rsp_if.
//
//  channel   direction  handshake      contents
//  i_req     in         valid/ready    kind, led_index, color_value
//  o_rsp     out        valid/ready    status, color_out, line_level, busy_res,
//                                      led_count, frame_done
//  i_cfg_*   in         write enable   register index, data (no read-back)
//
// One request at a time. Writes, rejected requests, starts on an empty chain and
// ticks that need no new color load the response register directly; reads, starts
// on a non-empty chain and ticks that move on to another LED of the chain first
// wait in the finish state for the registered read of the color store.
// Reset is immediate: per-entry valid bits make the whole store read as zero.
// A new request is taken while the response register drains in the same cycle;
// a stalled response holds off further requests.
`default_nettype none
module rgb_led_chain_serializer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rlcs_req_if.sink    i_req,
    rlcs_rsp_if.source  o_rsp,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [9:0]  i_cfg_data
);

    localparam int AW = rlcs_pkg::LED_AW;

    // Sequencer states and pending operations after a store read
    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIN  = 1'b1;

    localparam logic [1:0] FIN_READ  = 2'd0;
    localparam logic [1:0] FIN_START = 2'd1;
    localparam logic [1:0] FIN_NEXT  = 2'd2;

    // Configuration registers
    logic [7:0] r_one_hi, r_one_lo, r_zero_hi, r_zero_lo;
    logic [9:0] r_reset_lo;

    // Control state
    logic                 r_state, n_state;
    logic [1:0]           r_fin_op, n_fin_op;
    logic [1:0]           r_phase, n_phase;
    logic [9:0]           r_ticks, n_ticks;
    logic                 r_sending, n_sending;
    logic [6:0]           r_send_led, n_send_led;
    logic [4:0]           r_bit_pos, n_bit_pos;
    logic [6:0]           r_used, n_used;
    logic [23:0]          r_cur, n_cur;
    logic [rlcs_pkg::LED_SLOTS-1:0] r_vld, n_vld;

    // Color store
    logic [23:0] mem [rlcs_pkg::LED_SLOTS];
    logic [23:0] r_rd_data;
    logic        r_rd_vld;
    logic [AW-1:0] rd_addr;
    logic        mem_we;
    logic [23:0] fetched;

    // Response register
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_o_status;
    logic [23:0] r_o_color;
    logic        r_o_level, r_o_busy, r_o_done;
    logic [6:0]  r_o_count;

    // Response fields being loaded
    logic        load;
    logic [1:0]  ld_status;
    logic [23:0] ld_color;
    logic        ld_level, ld_done, level_fixed;

    logic        accept, idx_ok;
    logic [9:0]  tl;
    logic [4:0]  nb;
    logic [6:0]  nl;
    logic        led_step;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign idx_ok      = i_req.led_index < 8'(rlcs_pkg::LED_SLOTS);
    assign fetched     = r_rd_vld ? r_rd_data : 24'd0;

    // Request decode and line sequencing
    always_comb begin
        n_state     = r_state;
        n_fin_op    = r_fin_op;
        n_phase     = r_phase;
        n_ticks     = r_ticks;
        n_sending   = r_sending;
        n_send_led  = r_send_led;
        n_bit_pos   = r_bit_pos;
        n_used      = r_used;
        n_cur       = r_cur;
        n_vld       = r_vld;
        n_out_valid = r_out_valid && !o_rsp.ready;
        load        = 1'b0;
        ld_status   = rlcs_pkg::ST_OK;
        ld_color    = 24'd0;
        ld_level    = 1'b0;
        ld_done     = 1'b0;
        level_fixed = 1'b0;
        mem_we      = 1'b0;
        rd_addr     = i_req.led_index[AW-1:0];
        tl          = 10'd0;
        nb          = 5'd0;
        nl          = 7'd0;
        led_step    = 1'b0;

        if (r_state == S_FIN) begin
            // Store data is back: finish the pending operation
            load    = 1'b1;
            n_state = S_IDLE;
            unique case (r_fin_op)
                FIN_START, FIN_NEXT: begin
                    n_phase = rlcs_pkg::PH_HIGH;
                    n_cur   = fetched;
                    n_ticks = rlcs_pkg::at_least_one(rlcs_pkg::grb_bit(fetched, 5'd0)
                              ? 10'(r_one_hi) : 10'(r_zero_hi));
                    if (r_fin_op == FIN_NEXT) begin
                        level_fixed = 1'b1;
                        ld_level    = 1'b0;
                    end
                end
                default: begin
                    ld_color = fetched;
                end
            endcase
        end else if (accept) begin
            unique case (i_req.kind)
                rlcs_pkg::KIND_WRITE: begin
                    load = 1'b1;
                    if (!idx_ok) begin
                        ld_status = rlcs_pkg::ST_INVALID;
                    end else if (r_sending) begin
                        ld_status = rlcs_pkg::ST_BUSY;
                    end else begin
                        mem_we = 1'b1;
                        n_vld[i_req.led_index[AW-1:0]] = 1'b1;
                        if (i_req.led_index >= {1'b0, r_used}) begin
                            n_used = 7'(i_req.led_index) + 7'd1;
                        end
                    end
                end
                rlcs_pkg::KIND_READ: begin
                    if (!idx_ok) begin
                        load      = 1'b1;
                        ld_status = rlcs_pkg::ST_INVALID;
                    end else begin
                        n_state  = S_FIN;
                        n_fin_op = FIN_READ;
                    end
                end
                rlcs_pkg::KIND_START: begin
                    if (r_sending) begin
                        load      = 1'b1;
                        ld_status = rlcs_pkg::ST_BUSY;
                    end else begin
                        n_sending  = 1'b1;
                        n_send_led = 7'd0;
                        n_bit_pos  = 5'd0;
                        if (r_used == 7'd0) begin
                            load    = 1'b1;
                            n_phase = rlcs_pkg::PH_RESET;
                            n_ticks = rlcs_pkg::at_least_one(r_reset_lo);
                        end else begin
                            rd_addr  = '0;
                            n_state  = S_FIN;
                            n_fin_op = FIN_START;
                        end
                    end
                end
                default: begin
                    // Time tick
                    level_fixed = 1'b1;
                    ld_level    = (r_phase == rlcs_pkg::PH_HIGH);
                    load        = 1'b1;
                    if (r_phase != rlcs_pkg::PH_IDLE) begin
                        tl      = (r_ticks != 10'd0) ? r_ticks - 10'd1 : 10'd0;
                        n_ticks = tl;
                        if (tl == 10'd0) begin
                            unique case (r_phase)
                                rlcs_pkg::PH_HIGH: begin
                                    n_phase = rlcs_pkg::PH_LOW;
                                    n_ticks = rlcs_pkg::at_least_one(
                                        rlcs_pkg::grb_bit(r_cur, r_bit_pos)
                                        ? 10'(r_one_lo) : 10'(r_zero_lo));
                                end
                                rlcs_pkg::PH_LOW: begin
                                    nb = r_bit_pos + 5'd1;
                                    nl = r_send_led;
                                    if (nb >= 5'd24) begin
                                        nb       = 5'd0;
                                        nl       = r_send_led + 7'd1;
                                        led_step = 1'b1;
                                    end
                                    n_bit_pos  = nb;
                                    n_send_led = nl;
                                    if (nl >= r_used || nl >= 7'(rlcs_pkg::LED_SLOTS)) begin
                                        n_phase = rlcs_pkg::PH_RESET;
                                        n_ticks = rlcs_pkg::at_least_one(r_reset_lo);
                                    end else if (led_step) begin
                                        // Next LED's color comes from the store
                                        load     = 1'b0;
                                        rd_addr  = nl[AW-1:0];
                                        n_state  = S_FIN;
                                        n_fin_op = FIN_NEXT;
                                    end else begin
                                        n_phase = rlcs_pkg::PH_HIGH;
                                        n_ticks = rlcs_pkg::at_least_one(
                                            rlcs_pkg::grb_bit(r_cur, nb)
                                            ? 10'(r_one_hi) : 10'(r_zero_hi));
                                    end
                                end
                                default: begin
                                    n_phase    = rlcs_pkg::PH_IDLE;
                                    n_sending  = 1'b0;
                                    n_send_led = 7'd0;
                                    n_bit_pos  = 5'd0;
                                    ld_done    = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            endcase
        end

        if (!level_fixed) begin
            ld_level = (n_phase == rlcs_pkg::PH_HIGH);
        end
        if (load) begin
            n_out_valid = 1'b1;
        end
    end

    // Color store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_req.led_index[AW-1:0]] <= i_req.color_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_hi   <= 8'd4;
            r_one_lo   <= 8'd1;
            r_zero_hi  <= 8'd1;
            r_zero_lo  <= 8'd4;
            r_reset_lo <= 10'd200;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rlcs_pkg::CFG_ONE_HIGH:  r_one_hi   <= i_cfg_data[7:0];
                rlcs_pkg::CFG_ONE_LOW:   r_one_lo   <= i_cfg_data[7:0];
                rlcs_pkg::CFG_ZERO_HIGH: r_zero_hi  <= i_cfg_data[7:0];
                rlcs_pkg::CFG_ZERO_LOW:  r_zero_lo  <= i_cfg_data[7:0];
                rlcs_pkg::CFG_RESET_LOW: r_reset_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin_op    <= FIN_READ;
            r_phase     <= rlcs_pkg::PH_IDLE;
            r_ticks     <= 10'd0;
            r_sending   <= 1'b0;
            r_send_led  <= 7'd0;
            r_bit_pos   <= 5'd0;
            r_used      <= 7'd0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fin_op    <= n_fin_op;
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_sending   <= n_sending;
            r_send_led  <= n_send_led;
            r_bit_pos   <= n_bit_pos;
            r_used      <= n_used;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Cached color of the LED being sent and response payload
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (load) begin
            r_o_status <= ld_status;
            r_o_color  <= ld_color;
            r_o_level  <= ld_level;
            r_o_busy   <= n_sending;
            r_o_count  <= n_used;
            r_o_done   <= ld_done;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.color_out  = r_o_color;
    assign o_rsp.line_level = r_o_level;
    assign o_rsp.busy_res   = r_o_busy;
    assign o_rsp.led_count  = r_o_count;
    assign o_rsp.frame_done = r_o_done;

endmodule
`default_nettype wire
